// ----- sv/esd_pkg.sv -----
// Shared types, constants and helpers for the escape sequence decoder.
// No dependencies; the decoder modules and the testbench import this package.
`default_nettype none

package esd_pkg;

    // Byte codes that the decoder recognizes or emits.
    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_N    = 8'h6E;
    localparam logic [7:0] CHAR_R    = 8'h72;
    localparam logic [7:0] CHAR_T    = 8'h74;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [7:0] QUOTE     = 8'h22;
    localparam logic [7:0] NEWLINE   = 8'h0A;
    localparam logic [7:0] CRETURN   = 8'h0D;
    localparam logic [7:0] HTAB      = 8'h09;

    // Longest run of result bytes that one input item can cause.
    localparam int MAX_RUN   = 4;
    localparam int RUN_IDX_W = $clog2(MAX_RUN);
    localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

    // Run queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_TEXT = 4'b0001,
        PH_ESC  = 4'b0010,
        PH_HEX0 = 4'b0100,
        PH_HEX1 = 4'b1000
    } phase_t;

    // One run of result bytes caused by a single input item.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] data;
        logic [RUN_IDX_W-1:0]    last_idx;
        logic                    ends_text;
    } run_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_digit(input logic [7:0] b);
        hex_digit_t r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r.valid = 1'b1;
            r.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r.valid = 1'b1;
            r.value = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r.valid = 1'b1;
            r.value = 4'(b - 8'h37);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/esd_in_if.sv -----
// Input channel of the escape sequence decoder: one text byte or end flag.
// Depends on nothing.
`default_nettype none

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ----- sv/esd_out_if.sv -----
// Output channel of the escape sequence decoder: one decoded byte per transfer.
// Depends on nothing.
`default_nettype none

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded_byte;
    logic       run_last;
    logic       text_done;

    modport source (output valid, output decoded_byte, output run_last, output text_done,
                    input ready);
    modport sink   (input valid, input decoded_byte, input run_last, input text_done,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/escape_sequence_decoder_top.sv -----
// Escape sequence decoder, top level. Uses esd_pkg, esd_in_if, esd_out_if,
// esd_front, esd_queue and esd_back.
//
// Usage: text enters on text_in, one byte per transfer, or an end-of-text
// transfer that carries no byte. Decoded bytes leave on text_out, one per
// transfer. Each input transfer causes zero to four output transfers; the
// last of them has run_last set, and the end marker (decoded_byte zero) has
// text_done set. A backslash in plain text causes no output at all.
// Each run is stored in the run queue, then taken into the output register.
// Throughput: one input transfer per cycle as long as each causes at most
// one byte; the output port sends one byte per cycle while the receiver is
// ready, so runs of several bytes are absorbed by a four-entry run queue and
// text_in.ready drops only while that queue is full.
// Reset (rst_n low, asynchronous) returns the decoder to plain text and
// empties the queue and the output stage. When the receiver stalls, the
// current output byte holds, the queue fills, and then text_in stalls.
`default_nettype none

module escape_sequence_decoder_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    esd_in_if.sink     text_in,
    esd_out_if.source  text_out
);
    import esd_pkg::*;

    // Run handoff from the front to the queue.
    logic push;
    run_t push_run;
    logic queue_full;

    // Queue head as seen by the back.
    run_t head_run;
    logic head_valid;
    logic pop;

    // The front classifies each byte against the current escape phase.
    esd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .queue_full (queue_full),
        .push       (push),
        .push_run   (push_run)
    );

    // The queue lets the front keep taking bytes while the back drains a run.
    esd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .full       (queue_full),
        .pop        (pop),
        .head_run   (head_run),
        .head_valid (head_valid)
    );

    // The back holds the output register and steps through each run.
    esd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_run   (head_run),
        .head_valid (head_valid),
        .pop        (pop),
        .text_out   (text_out)
    );

endmodule

`default_nettype wire

// ----- sv/esd_front.sv -----
// Front of the decoder: tracks the escape phase and turns each input transfer
// into a run of zero to four result bytes. Uses esd_pkg and esd_in_if.
`default_nettype none

module esd_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    esd_in_if.sink           text_in,
    input  wire logic        queue_full,
    output logic             push,
    output esd_pkg::run_t    push_run
);
    import esd_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [7:0]           raw_reg, raw_next;
    logic [3:0]           acc_reg, acc_next;
    logic [RUN_CNT_W-1:0] count;
    logic                 accept;
    hex_digit_t           hv;
    run_t                 run;

    assign text_in.ready = !queue_full;
    assign accept        = text_in.valid && text_in.ready;

    always_comb
    begin
        hv         = hex_digit(text_in.text_byte);
        run        = '0;
        count      = '0;
        phase_next = phase_reg;
        raw_next   = raw_reg;
        acc_next   = acc_reg;
        if (text_in.end_of_text)
        begin
            // Flush whatever escape is pending, then the end marker (zero byte).
            phase_next    = PH_TEXT;
            run.ends_text = 1'b1;
            unique case (phase_reg)
                PH_TEXT: count = RUN_CNT_W'(1);
                PH_ESC:
                begin
                    run.data[0] = BACKSLASH;
                    count       = RUN_CNT_W'(2);
                end
                PH_HEX0:
                begin
                    run.data[0] = BACKSLASH;
                    run.data[1] = CHAR_X;
                    count       = RUN_CNT_W'(3);
                end
                PH_HEX1:
                begin
                    if (acc_reg != 4'd0)
                    begin
                        run.data[0] = {4'd0, acc_reg};
                        count       = RUN_CNT_W'(2);
                    end
                    else
                    begin
                        run.data[0] = BACKSLASH;
                        run.data[1] = CHAR_X;
                        run.data[2] = raw_reg;
                        count       = RUN_CNT_W'(4);
                    end
                end
                default: phase_next = PH_TEXT;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_TEXT:
                begin
                    if (text_in.text_byte == BACKSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        run.data[0] = text_in.text_byte;
                        count       = RUN_CNT_W'(1);
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_TEXT;
                    count      = RUN_CNT_W'(1);
                    unique case (text_in.text_byte)
                        CHAR_N:    run.data[0] = NEWLINE;
                        CHAR_R:    run.data[0] = CRETURN;
                        CHAR_T:    run.data[0] = HTAB;
                        BACKSLASH: run.data[0] = BACKSLASH;
                        QUOTE:     run.data[0] = QUOTE;
                        CHAR_X:
                        begin
                            phase_next = PH_HEX0;
                            count      = '0;
                        end
                        default:
                        begin
                            // Unknown escape keeps its backslash.
                            run.data[0] = BACKSLASH;
                            run.data[1] = text_in.text_byte;
                            count       = RUN_CNT_W'(2);
                        end
                    endcase
                end
                PH_HEX0:
                begin
                    if (hv.valid)
                    begin
                        raw_next   = text_in.text_byte;
                        acc_next   = hv.value;
                        phase_next = PH_HEX1;
                    end
                    else
                    begin
                        // A \x with no digits is kept literally.
                        run.data[0] = BACKSLASH;
                        run.data[1] = CHAR_X;
                        if (text_in.text_byte == BACKSLASH)
                        begin
                            phase_next = PH_ESC;
                            count      = RUN_CNT_W'(2);
                        end
                        else
                        begin
                            phase_next  = PH_TEXT;
                            run.data[2] = text_in.text_byte;
                            count       = RUN_CNT_W'(3);
                        end
                    end
                end
                PH_HEX1:
                begin
                    if (hv.valid)
                    begin
                        phase_next = PH_TEXT;
                        if ({acc_reg, hv.value} != 8'd0)
                        begin
                            run.data[0] = {acc_reg, hv.value};
                            count       = RUN_CNT_W'(1);
                        end
                        else
                        begin
                            // A zero value passes through as its raw bytes.
                            run.data[0] = BACKSLASH;
                            run.data[1] = CHAR_X;
                            run.data[2] = raw_reg;
                            run.data[3] = text_in.text_byte;
                            count       = RUN_CNT_W'(4);
                        end
                    end
                    else
                    begin
                        // Close the one-digit escape, then treat the byte as text.
                        phase_next = (text_in.text_byte == BACKSLASH) ? PH_ESC : PH_TEXT;
                        if (acc_reg != 4'd0)
                        begin
                            run.data[0] = {4'd0, acc_reg};
                            run.data[1] = text_in.text_byte;
                            count       = (text_in.text_byte == BACKSLASH)
                                          ? RUN_CNT_W'(1) : RUN_CNT_W'(2);
                        end
                        else
                        begin
                            run.data[0] = BACKSLASH;
                            run.data[1] = CHAR_X;
                            run.data[2] = raw_reg;
                            run.data[3] = text_in.text_byte;
                            count       = (text_in.text_byte == BACKSLASH)
                                          ? RUN_CNT_W'(3) : RUN_CNT_W'(4);
                        end
                    end
                end
                default: phase_next = PH_TEXT;
            endcase
        end
        run.last_idx = RUN_IDX_W'(count - RUN_CNT_W'(1));
    end

    assign push     = accept && (count != '0);
    assign push_run = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg <= raw_next;
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/esd_queue.sv -----
// Short queue of byte runs between the front and the back of the decoder.
// Uses esd_pkg.
`default_nettype none

module esd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire esd_pkg::run_t  push_run,
    output logic                full,
    input  wire logic           pop,
    output esd_pkg::run_t       head_run,
    output logic                head_valid
);
    import esd_pkg::*;

    run_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign full       = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_run   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

`default_nettype wire

// ----- sv/esd_back.sv -----
// Back of the decoder: takes runs from the queue and sends their bytes one per
// transfer on the output channel. Uses esd_pkg and esd_out_if.
`default_nettype none

module esd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire esd_pkg::run_t  head_run,
    input  wire logic           head_valid,
    output logic                pop,
    esd_out_if.source           text_out
);
    import esd_pkg::*;

    run_t                 cur_reg;
    logic                 cur_valid_reg;
    logic [RUN_IDX_W-1:0] idx_reg;
    logic                 last_byte, fire;

    assign last_byte = (idx_reg == cur_reg.last_idx);
    assign fire      = cur_valid_reg && text_out.ready;
    assign pop       = head_valid && (!cur_valid_reg || (fire && last_byte));

    assign text_out.valid        = cur_valid_reg;
    assign text_out.decoded_byte = cur_reg.data[idx_reg];
    assign text_out.run_last     = last_byte;
    assign text_out.text_done    = last_byte && cur_reg.ends_text;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                cur_valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + RUN_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_run;
        end
    end

endmodule

`default_nettype wire

// ----- sv/esd_checker.sv -----
// Port-level checks for the escape sequence decoder, bound to its top level.
// Depends on escape_sequence_decoder_top.
`default_nettype none

module esd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       in_end,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_last,
    input wire logic       out_done
);

    // A stalled output transfer holds its byte and flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(out_last) && $stable(out_done))
        else $error("output transfer changed while stalled");

    // The end marker closes its run and carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_done |-> out_last && (out_byte == 8'd0))
        else $error("end marker is not a zero byte closing its run");

    // An accepted end of text always leaves output waiting once its run can have reached the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_end |-> ##2 out_valid)
        else $error("end of text produced no pending output");

endmodule

bind escape_sequence_decoder_top esd_checker u_esd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text_in.valid),
    .in_ready  (text_in.ready),
    .in_end    (text_in.end_of_text),
    .out_valid (text_out.valid),
    .out_ready (text_out.ready),
    .out_byte  (text_out.decoded_byte),
    .out_last  (text_out.run_last),
    .out_done  (text_out.text_done)
);

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for escape_sequence_decoder_top: directed escapes, then random text.
// Depends on esd_pkg, esd_in_if, esd_out_if and the decoder RTL; reads no files.
// A scoreboard class predicts every decoded byte and checks each output transfer in order.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    // Receiver hold-off that forces the run queue to fill and text_in to stall.
    localparam int HOLD_CYCLES  = 300;
    // Cycles allowed after the last expected byte, to catch stray output.
    localparam int DRAIN_CYCLES = 10;
    // Number of random input transfers after the directed opening.
    localparam int RANDOM_ITEMS = 500;

    // One decoded byte as it should appear on text_out.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } decoded_t;

    // The scoreboard keeps its own copy of the decoder state. Every accepted input
    // transfer is run through the same escape rules, and the bytes it produces are
    // queued in order; every output transfer is compared with the oldest one.
    class decode_scoreboard;
        phase_t     phase;
        logic [7:0] first_digit_raw;
        logic [3:0] digit_acc;
        decoded_t   expected_bytes[$];
        int         mismatches;

        function new();
            phase           = PH_TEXT;
            first_digit_raw = '0;
            digit_acc       = '0;
            mismatches      = 0;
        endfunction

        // Value of a hex digit of either case, or -1 for any other byte.
        function int digit_value(logic [7:0] b);
            if (b >= "0" && b <= "9")
                return int'(b) - int'("0");
            if (b >= "a" && b <= "f")
                return int'(b) - int'("a") + 10;
            if (b >= "A" && b <= "F")
                return int'(b) - int'("A") + 10;
            return -1;
        endfunction

        function void emit(logic [7:0] b, logic done);
            decoded_t e;
            e.data = b;
            e.last = 1'b0;
            e.done = done;
            expected_bytes.push_back(e);
        endfunction

        // A byte outside any escape: a backslash opens one, anything else passes.
        function void take_plain(logic [7:0] b);
            if (b == BACKSLASH)
                phase = PH_ESC;
            else
            begin
                phase = PH_TEXT;
                emit(b, 1'b0);
            end
        endfunction

        // A hex escape that ends after one digit; a zero value goes out as raw text.
        function void close_one_digit();
            if (digit_acc != 4'h0)
                emit({4'h0, digit_acc}, 1'b0);
            else
            begin
                emit(BACKSLASH, 1'b0);
                emit(CHAR_X, 1'b0);
                emit(first_digit_raw, 1'b0);
            end
        endfunction

        function void note_input(logic [7:0] b, logic eot);
            int         n_old;
            int         d;
            logic [7:0] v;
            n_old = expected_bytes.size();
            d     = digit_value(b);
            if (eot)
            begin
                case (phase)
                    PH_ESC:
                        emit(BACKSLASH, 1'b0);
                    PH_HEX0:
                    begin
                        emit(BACKSLASH, 1'b0);
                        emit(CHAR_X, 1'b0);
                    end
                    PH_HEX1:
                        close_one_digit();
                    default:
                        ;
                endcase
                phase = PH_TEXT;
                emit(8'h00, 1'b1);
            end
            else
            begin
                case (phase)
                    PH_TEXT:
                        take_plain(b);
                    PH_ESC:
                    begin
                        phase = PH_TEXT;
                        case (b)
                            CHAR_N:    emit(NEWLINE, 1'b0);
                            CHAR_R:    emit(CRETURN, 1'b0);
                            CHAR_T:    emit(HTAB, 1'b0);
                            BACKSLASH: emit(BACKSLASH, 1'b0);
                            QUOTE:     emit(QUOTE, 1'b0);
                            CHAR_X:    phase = PH_HEX0;
                            default:
                            begin
                                emit(BACKSLASH, 1'b0);
                                emit(b, 1'b0);
                            end
                        endcase
                    end
                    PH_HEX0:
                    begin
                        if (d >= 0)
                        begin
                            first_digit_raw = b;
                            digit_acc       = d[3:0];
                            phase           = PH_HEX1;
                        end
                        else
                        begin
                            emit(BACKSLASH, 1'b0);
                            emit(CHAR_X, 1'b0);
                            take_plain(b);
                        end
                    end
                    default:
                    begin
                        if (d >= 0)
                        begin
                            v     = {digit_acc, d[3:0]};
                            phase = PH_TEXT;
                            if (v != 8'h00)
                                emit(v, 1'b0);
                            else
                            begin
                                emit(BACKSLASH, 1'b0);
                                emit(CHAR_X, 1'b0);
                                emit(first_digit_raw, 1'b0);
                                emit(b, 1'b0);
                            end
                        end
                        else
                        begin
                            close_one_digit();
                            take_plain(b);
                        end
                    end
                endcase
            end
            if (expected_bytes.size() > n_old)
                expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        endfunction

        function void check_output(logic [7:0] data, logic last, logic done);
            decoded_t want;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: byte %02h run_last %0b text_done %0b",
                             data, last, done);
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data || last !== want.last || done !== want.done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected byte %02h run_last %0b text_done %0b,",
                             want.data, want.last, want.done,
                             " got byte %02h run_last %0b text_done %0b",
                             data, last, done);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    esd_in_if  text_in();
    esd_out_if text_out();

    escape_sequence_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in.sink),
        .text_out (text_out.source)
    );

    decode_scoreboard sb;

    // Transfers seen on text_in; the receiver uses this to time its long hold-off.
    int items_accepted = 0;
    int items_sent     = 0;
    // While nonzero, the sender offers items back to back with no gaps.
    int burst_left     = 0;
    bit hold_done      = 1'b0;

    // 8 ns clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // A random hex digit of either case. At least a quarter of them are zero, so that
    // zero-valued escapes, which come out as raw text, turn up often.
    function automatic logic [7:0] hex_char();
        int v;
        if ($urandom_range(0, 3) == 0)
            return "0";
        v = $urandom_range(0, 21);
        if (v < 10)
            return 8'("0" + v);
        if (v < 16)
            return 8'("a" + v - 10);
        return 8'("A" + v - 16);
    endfunction

    // A byte that is not a hex digit; used to cut a hex escape short.
    function automatic logic [7:0] non_hex_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Monitors. Both sample at the rising edge, so they see the values that the
    // decoder saw; a transfer is an edge at which valid and ready are both high.
    always @(posedge clk)
    begin
        if (rst_n && text_in.valid && text_in.ready)
        begin
            sb.note_input(text_in.text_byte, text_in.end_of_text);
            items_accepted++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && text_out.valid && text_out.ready)
            sb.check_output(text_out.decoded_byte, text_out.run_last, text_out.text_done);
    end

    // Offers one input item after a random gap and returns at the edge where it is
    // taken. It is always entered at a rising edge, and valid is only ever written
    // once per edge: with no gap it simply stays high for the next item.
    task automatic send_item(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(20, 40);
        end
        if (gap > 0)
        begin
            text_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_in.valid       <= 1'b1;
        text_in.text_byte   <= b;
        text_in.end_of_text <= eot;
        @(posedge clk);
        while (!text_in.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    // End of text; the byte field is meaningless here, so it carries noise.
    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // One random piece of text. Most are plain bytes or well-formed escapes with
    // random content, so that every phase of the decoder is visited; the rest are
    // broken escapes, ends of text, some inside an escape, and raw noise.
    task automatic send_random_piece();
        int         kind;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            // Plain text byte.
            b = 8'($urandom_range(0, 255));
            if (b == BACKSLASH)
                b = 8'h41;
            send_byte(b);
        end
        else if (kind < 40)
        begin
            // One of the named escapes.
            send_byte(BACKSLASH);
            case ($urandom_range(0, 4))
                0:       send_byte(CHAR_N);
                1:       send_byte(CHAR_R);
                2:       send_byte(CHAR_T);
                3:       send_byte(BACKSLASH);
                default: send_byte(QUOTE);
            endcase
        end
        else if (kind < 65)
        begin
            // Hex escape with one or two digits; one digit is followed by a
            // non-hex byte, which then goes through as text or a new escape.
            send_byte(BACKSLASH);
            send_byte(CHAR_X);
            send_byte(hex_char());
            if ($urandom_range(0, 2) != 0)
                send_byte(hex_char());
            else if ($urandom_range(0, 1) == 0)
                send_byte(BACKSLASH);
            else
                send_byte(non_hex_char());
        end
        else if (kind < 72)
        begin
            // Hex escape with no digits at all.
            send_byte(BACKSLASH);
            send_byte(CHAR_X);
            send_byte($urandom_range(0, 1) ? BACKSLASH : non_hex_char());
        end
        else if (kind < 80)
        begin
            // Backslash followed by anything, mostly unknown escapes.
            send_byte(BACKSLASH);
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 86)
            send_end();
        else if (kind < 92)
        begin
            // Text that ends inside an escape.
            send_byte(BACKSLASH);
            n = $urandom_range(0, 2);
            if (n > 0)
                send_byte(CHAR_X);
            if (n > 1)
                send_byte(hex_char());
            send_end();
        end
        else
        begin
            // Raw noise, backslashes included.
            n = $urandom_range(1, 4);
            repeat (n)
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver: ready in stretches of random length, some of them long, with random
    // gaps between. Once, after enough traffic, it holds off for a long stretch so
    // that the output stage and the run queue fill and text_in has to stall.
    initial
    begin
        int run;
        int gap;
        text_out.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && items_accepted >= 150)
            begin
                text_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            run = $urandom_range(0, 99);
            if (run < 70)
                run = $urandom_range(1, 6);
            else if (run < 90)
                run = $urandom_range(7, 20);
            else
                run = $urandom_range(40, 100);
            text_out.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                text_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Main sequence: reset, a directed opening, random text, then drain and report.
    initial
    begin
        rst_n               = 1'b0;
        text_in.valid       = 1'b0;
        text_in.text_byte   = 8'h00;
        text_in.end_of_text = 1'b0;
        sb                  = new();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Zero byte as plain text, and a backslash before the top byte value,
        // which is an unknown escape.
        send_byte(8'h00);
        send_byte(BACKSLASH);
        send_byte(8'hFF);
        // Three of the named escapes: newline, backslash and quote.
        send_byte(BACKSLASH);
        send_byte(CHAR_N);
        send_byte(BACKSLASH);
        send_byte(BACKSLASH);
        send_byte(BACKSLASH);
        send_byte(QUOTE);
        // Two-digit hex escape with mixed case.
        send_byte(BACKSLASH);
        send_byte(CHAR_X);
        send_byte("A");
        send_byte("b");
        // Two-digit hex escape of value zero, which comes out as raw text.
        send_byte(BACKSLASH);
        send_byte(CHAR_X);
        send_byte("0");
        send_byte("0");
        // Hex escape with no digits whose next byte opens a new escape, and an
        // end of text that has to flush that pending backslash.
        send_byte(BACKSLASH);
        send_byte(CHAR_X);
        send_byte(BACKSLASH);
        send_end();
        // One hex digit closed by a backslash, then an end of text right after \x.
        send_byte(BACKSLASH);
        send_byte(CHAR_X);
        send_byte("7");
        send_byte(BACKSLASH);
        send_byte(CHAR_X);
        send_end();
        // End of text after a single zero digit.
        send_byte(BACKSLASH);
        send_byte(CHAR_X);
        send_byte("0");
        send_end();

        while (items_sent < 31 + RANDOM_ITEMS)
            send_random_piece();
        send_end();
        text_in.valid <= 1'b0;

        // Wait for every predicted byte, then a little longer to catch strays.
        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run could take.
    initial
    begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ----- escape_sequence_decoder_top.f -----
sv/esd_pkg.sv
sv/esd_in_if.sv
sv/esd_out_if.sv
sv/esd_front.sv
sv/esd_queue.sv
sv/esd_back.sv
sv/escape_sequence_decoder_top.sv
sv/esd_checker.sv
sim/testbench.sv
